// ===== rtl/tsp_pkg.sv =====
// Shared constants and types for the trapezoidal servo profile unit.
package tsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANG_W      = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DPU   = 3'd5;

  // target select codes
  localparam logic [1:0] SEL_CLOSE  = 2'd0;
  localparam logic [1:0] SEL_MID    = 2'd1;
  localparam logic [1:0] SEL_OPEN   = 2'd2;
  localparam logic [1:0] SEL_CENTRE = 2'd3;

  // motion stages
  localparam logic [1:0] STG_ACCEL  = 2'd0;
  localparam logic [1:0] STG_CRUISE = 2'd1;
  localparam logic [1:0] STG_DECEL  = 2'd2;

  localparam logic [ANG_W-1:0] CENTRE_ANGLE = 8'd90;
  localparam logic [ANG_W-1:0] SERVO_MAX    = 8'd180;

  localparam logic [15:0] RST_ACCEL = 16'd360;
  localparam logic [9:0]  RST_TOP   = 10'd180;
  localparam logic [15:0] RST_DPU   = 16'd256;

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

endpackage

// ===== rtl/tsp_div.sv =====
// Restoring divider, one quotient bit per cycle while run is asserted, MSB of the dividend first.
module tsp_div
  import tsp_pkg::*;
#(
  parameter int DVD_W = 35,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] dvd_sr;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic             fit;

  assign rem_sh = {rem, dvd_sr[DVD_W-1]};
  assign fit    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd_sr <= dividend;
      dvs    <= divisor;
      rem    <= '0;
      quo    <= '0;
    end else if (ctrl.run) begin
      dvd_sr <= {dvd_sr[DVD_W-2:0], 1'b0};
      rem    <= fit ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
      quo    <= {quo[DVD_W-2:0], fit};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/trapezoidal_servo_profile_unit.sv =====
// Trapezoidal servo motion profile generator, top level.
//
//   channel | signals                                  | transfer when
//   --------+------------------------------------------+-------------------------
//   cmd in  | in_valid, in_ready, mode, target_select  | in_valid & in_ready
//   result  | out_valid, out_ready, servo_position,    | out_valid & out_ready
//           | moving                                   |
//   config  | cfg_we, cfg_index, cfg_data              | cfg_we
//
// A start command, or a tick while idle, goes straight to the done state. A
// tick during a move runs phases 1 and 2, the decision, phase 3 and the move,
// or ends at the decision when it only changes stage or snaps onto the goal.
// Reset is synchronous and restores the control and configuration registers
// and the centre position. A stalled result sits in the output register; the
// next command is taken meanwhile and its result waits until that register
// is free.
module trapezoidal_servo_profile_unit
  import tsp_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [1:0]            target_select,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANG_W-1:0]      servo_position,
  output logic                  moving
);

  localparam int F      = FRAC_BITS;
  localparam int POS_W  = 10 + F;
  localparam int SPD_W  = 11 + F;
  localparam int DW     = POS_W - F;
  localparam int TW     = $clog2(TICKS_PER_SECOND + 1);
  localparam int DV_W   = TW + 16;
  localparam int DVD_W  = SPD_W + 8;
  localparam int VQ_W   = SPD_W - F + 8;
  localparam int SQ_W   = 2 * VQ_W;
  localparam int K_W    = 32;
  localparam int L_W    = DW + K_W;
  localparam int FAR_SH = 9;
  localparam int CMP_W  = L_W + FAR_SH;
  localparam int PH1    = 16 + F;
  localparam int PH2    = DW;
  localparam int PH3    = DVD_W;
  localparam int CNT_W  = $clog2(PH3);

  localparam logic [TW-1:0]    TPS_C   = TW'(TICKS_PER_SECOND);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_P1     = 3'd1;
  localparam logic [2:0] S_P2     = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_P3     = 3'd4;
  localparam logic [2:0] S_MOVE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;

  logic [ANG_W-1:0] close_point, mid_point, open_point;
  logic [15:0]      accel_rate, degrees_per_unit;
  logic [9:0]       top_speed;

  logic [POS_W-1:0] pos;
  logic [SPD_W-1:0] speed;
  logic [1:0]       stage;
  logic [ANG_W-1:0] goal;
  logic             busy;

  logic [15:0]      dpu_sr;
  logic [K_W-1:0]   acc_k;
  logic [DV_W-1:0]  acc_dv;
  logic [VQ_W-1:0]  vq, vq_sr;
  logic [SQ_W-1:0]  acc_sq;
  logic [DW-1:0]    d_sr;
  logic [L_W-1:0]   acc_l;
  logic [SPD_W-1:0] s_step;

  logic             in_xfer, out_free, last;
  logic [15:0]      a_nz, dpu_nz;
  logic [POS_W-1:0] goal_fix, sel_fix, span_fix;
  logic [ANG_W-1:0] sel_goal;
  logic [SPD_W-1:0] top_fix, vt, speed_next, va;
  logic [1:0]       stage_next;
  logic             far, adv, snap;
  logic [DVD_W:0]   sum_up;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] ipart_w;
  logic [DW-1:0]    ipart;

  div_ctrl_t        div_ctrl;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DV_W-1:0]  div_dvs;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  assign a_nz     = (accel_rate == '0) ? 16'd1 : accel_rate;
  assign dpu_nz   = (degrees_per_unit == '0) ? 16'd1 : degrees_per_unit;
  assign goal_fix = {2'b00, goal, {F{1'b0}}};
  assign top_fix  = {1'b0, top_speed, {F{1'b0}}};
  assign vt       = (stage == STG_CRUISE) ? top_fix : speed;
  assign span_fix = (pos >= goal_fix) ? pos - goal_fix : goal_fix - pos;

  always_comb begin
    unique case (target_select)
      SEL_CLOSE: sel_goal = close_point;
      SEL_MID:   sel_goal = mid_point;
      SEL_OPEN:  sel_goal = open_point;
      SEL_CENTRE: sel_goal = CENTRE_ANGLE;
      default:   sel_goal = CENTRE_ANGLE;
    endcase
  end
  assign sel_fix = {2'b00, sel_goal, {F{1'b0}}};

  always_comb begin
    unique case (state)
      S_P1:    last = (cnt == CNT_W'(PH1 - 1));
      S_P2:    last = (cnt == CNT_W'(PH2 - 1));
      S_P3:    last = (cnt == CNT_W'(PH3 - 1));
      default: last = 1'b0;
    endcase
  end

  // braking test: d*a*dpu*2^9 > vq^2, then the stage decision
  always_comb begin
    far        = {acc_l, {FAR_SH{1'b0}}} > CMP_W'(acc_sq);
    stage_next = stage;
    speed_next = speed;
    adv        = 1'b0;
    snap       = 1'b0;
    va         = speed;
    case (stage)
      STG_ACCEL: begin
        if (far) begin
          if (speed < top_fix) begin
            speed_next = speed + s_step;
            adv        = 1'b1;
            va         = speed_next;
          end else begin
            stage_next = STG_CRUISE;
          end
        end else begin
          stage_next = STG_DECEL;
        end
      end
      STG_CRUISE: begin
        if (far) begin
          adv = 1'b1;
          va  = top_fix;
        end else begin
          stage_next = STG_DECEL;
        end
      end
      default: begin
        if (speed != '0) begin
          speed_next = (s_step > speed) ? '0 : speed - s_step;
          adv        = 1'b1;
          va         = speed_next;
        end else begin
          snap = 1'b1;
        end
      end
    endcase
  end

  // position step with saturation at both ends
  always_comb begin
    sum_up = {1'b0, DVD_W'(pos)} + {1'b0, div_q};
    if (pos < goal_fix) begin
      pos_next = (sum_up > (DVD_W + 1)'(POS_MAX)) ? POS_MAX : sum_up[POS_W-1:0];
    end else begin
      pos_next = (div_q > DVD_W'(pos)) ? '0 : pos - div_q[POS_W-1:0];
    end
  end

  // shared divider: speed step in phase 1, position step in phase 3
  assign div_ctrl.load = (in_xfer && !mode && busy) || (state == S_DECIDE && adv);
  assign div_ctrl.run  = (state == S_P1) || (state == S_P3);
  assign div_dvd = (state == S_IDLE) ? {a_nz, {(DVD_W - 16){1'b0}}} : {va, 8'h00};
  assign div_dvs = (state == S_IDLE) ? DV_W'(TPS_C) : acc_dv;

  tsp_div #(
    .DVD_W(DVD_W),
    .DVS_W(DV_W)
  ) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      close_point      <= CENTRE_ANGLE;
      mid_point        <= CENTRE_ANGLE;
      open_point       <= CENTRE_ANGLE;
      accel_rate       <= RST_ACCEL;
      top_speed        <= RST_TOP;
      degrees_per_unit <= RST_DPU;
      pos              <= {2'b00, CENTRE_ANGLE, {F{1'b0}}};
      speed            <= '0;
      stage            <= STG_ACCEL;
      goal             <= CENTRE_ANGLE;
      busy             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLOSE: close_point      <= cfg_data[ANG_W-1:0];
          CFG_MID:   mid_point        <= cfg_data[ANG_W-1:0];
          CFG_OPEN:  open_point       <= cfg_data[ANG_W-1:0];
          CFG_ACCEL: accel_rate       <= cfg_data;
          CFG_TOP:   top_speed        <= cfg_data[9:0];
          CFG_DPU:   degrees_per_unit <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cnt <= '0;
            if (mode) begin
              goal  <= sel_goal;
              speed <= '0;
              stage <= STG_ACCEL;
              busy  <= (pos != sel_fix);
              state <= S_DONE;
            end else if (!busy) begin
              state <= S_DONE;
            end else begin
              state <= S_P1;
            end
          end
        end
        S_P1, S_P2, S_P3: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) begin
            state <= (state == S_P1) ? S_P2 : (state == S_P2) ? S_DECIDE : S_MOVE;
          end
        end
        S_DECIDE: begin
          stage <= stage_next;
          speed <= speed_next;
          if (snap) begin
            pos  <= goal_fix;
            busy <= 1'b0;
          end
          state <= adv ? S_P3 : S_DONE;
        end
        S_MOVE: begin
          pos   <= pos_next;
          busy  <= (pos_next != goal_fix);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // shift-add datapath, MSB of each multiplier first
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dpu_sr <= dpu_nz;
      acc_k  <= '0;
      acc_dv <= '0;
      vq     <= vt[SPD_W-1:F-8];
      vq_sr  <= vt[SPD_W-1:F-8];
      acc_sq <= '0;
      d_sr   <= span_fix[POS_W-1:F];
      acc_l  <= '0;
    end
    if (state == S_P1) begin
      if (cnt < CNT_W'(16)) begin
        dpu_sr <= {dpu_sr[14:0], 1'b0};
        acc_k  <= {acc_k[K_W-2:0], 1'b0} + (dpu_sr[15] ? {16'h0000, a_nz} : '0);
        acc_dv <= {acc_dv[DV_W-2:0], 1'b0} + (dpu_sr[15] ? DV_W'(TPS_C) : '0);
      end
      if (cnt < CNT_W'(VQ_W)) begin
        vq_sr  <= {vq_sr[VQ_W-2:0], 1'b0};
        acc_sq <= {acc_sq[SQ_W-2:0], 1'b0} + (vq_sr[VQ_W-1] ? SQ_W'(vq) : '0);
      end
    end
    if (state == S_P2) begin
      // speed step, at least one LSB
      if (cnt == '0) begin
        s_step <= (div_q[SPD_W-1:0] == '0) ? SPD_W'(1) : div_q[SPD_W-1:0];
      end
      d_sr  <= {d_sr[DW-2:0], 1'b0};
      acc_l <= {acc_l[L_W-2:0], 1'b0} + (d_sr[DW-1] ? L_W'(acc_k) : '0);
    end
    if (state == S_DONE && out_free) begin
      servo_position <= (ipart > DW'(SERVO_MAX)) ? SERVO_MAX : ipart[ANG_W-1:0];
      moving         <= busy;
    end
  end

  assign ipart_w = pos >> F;
  assign ipart   = ipart_w[DW-1:0];

endmodule

// ===== rtl/tsp_checker.sv =====
// Port-level checker for the servo profile unit, bound to the top level.
module tsp_checker
  import tsp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ANG_W-1:0] servo_position,
  input logic             moving
);

  // result angle never leaves the servo range
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> servo_position <= SERVO_MAX)
    else $error("servo_position above servo range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(servo_position) && $stable(moving))
    else $error("stalled result changed");

  // one command in flight: no transfer in the cycle after one
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in flight");

  // reset empties the result register and opens the command side
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state after reset wrong");

endmodule

bind trapezoidal_servo_profile_unit tsp_checker u_tsp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .servo_position (servo_position),
  .moving         (moving)
);

// ===== test/trapezoidal_servo_profile_unit_tb.sv =====
// Self-checking testbench for the trapezoidal servo profile unit.
`timescale 1ns / 1ps

module trapezoidal_servo_profile_unit_tb;
  import tsp_pkg::*;

  localparam int FRAC  = 16;
  localparam int TICKS = 1000;

  typedef longint unsigned u64_t;

  localparam u64_t POS_TOP = (u64_t'(1) << (10 + FRAC)) - 1;

  typedef struct packed {
    logic [ANG_W-1:0] servo_position;
    logic             moving;
  } servo_out_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  mode;
  logic [1:0]            target_select;
  logic                  out_valid;
  logic                  out_ready;
  logic [ANG_W-1:0]      servo_position;
  logic                  moving;

  trapezoidal_servo_profile_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .target_select  (target_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .servo_position (servo_position),
    .moving         (moving)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // profile predictor state and register copy
  logic [7:0]  close_deg, mid_deg, open_deg;
  logic [15:0] accel_cfg, dpu_cfg;
  logic [9:0]  top_cfg;
  u64_t        pos_fix, spd_fix;
  logic [1:0]  stage;
  logic [7:0]  goal;
  bit          in_motion;

  servo_out_t pending_positions[$];
  int         mismatches = 0;
  int         items_sent = 0;
  bit         idle_on = 1'b1;
  int         out_hold_cycles = 0;

  function automatic u64_t at_least_one(u64_t v);
    return (v == 0) ? u64_t'(1) : v;
  endfunction

  // remaining distance still exceeds the braking distance at speed v
  function automatic bit beyond_braking(u64_t v);
    u64_t g, remain, vq, lhs, rhs;
    g      = u64_t'(goal) << FRAC;
    remain = ((g > pos_fix) ? g - pos_fix : pos_fix - g) >> FRAC;
    vq     = v >> (FRAC - 8);
    lhs    = remain * 2 * at_least_one(u64_t'(accel_cfg)) *
             at_least_one(u64_t'(dpu_cfg)) * 65536;
    rhs    = 256 * vq * vq;
    return lhs > rhs;
  endfunction

  function automatic void step_toward_goal(u64_t v);
    u64_t s, g;
    s = (v * 256) / (u64_t'(TICKS) * at_least_one(u64_t'(dpu_cfg)));
    g = u64_t'(goal) << FRAC;
    if (pos_fix < g) begin
      pos_fix = (s > POS_TOP - pos_fix) ? POS_TOP : pos_fix + s;
    end else begin
      pos_fix = (s > pos_fix) ? 0 : pos_fix - s;
    end
  endfunction

  function automatic u64_t speed_increment();
    return at_least_one((at_least_one(u64_t'(accel_cfg)) << FRAC) / u64_t'(TICKS));
  endfunction

  function automatic servo_out_t next_servo_output(bit m, logic [1:0] sel);
    u64_t       top_fix, ipart, s;
    servo_out_t r;
    top_fix = u64_t'(top_cfg) << FRAC;
    if (m) begin
      case (sel)
        SEL_CLOSE: goal = close_deg;
        SEL_MID:   goal = mid_deg;
        SEL_OPEN:  goal = open_deg;
        default:   goal = CENTRE_ANGLE;
      endcase
      spd_fix   = 0;
      stage     = STG_ACCEL;
      in_motion = (pos_fix != (u64_t'(goal) << FRAC));
    end else if (in_motion) begin
      case (stage)
        STG_ACCEL: begin
          if (!beyond_braking(spd_fix)) begin
            stage = STG_DECEL;
          end else if (spd_fix < top_fix) begin
            spd_fix = spd_fix + speed_increment();
            step_toward_goal(spd_fix);
          end else begin
            stage = STG_CRUISE;
          end
        end
        STG_CRUISE: begin
          if (beyond_braking(top_fix)) step_toward_goal(top_fix);
          else stage = STG_DECEL;
        end
        default: begin
          // decelerate; once stopped, snap onto the goal
          if (spd_fix > 0) begin
            s = speed_increment();
            spd_fix = (s > spd_fix) ? 0 : spd_fix - s;
            step_toward_goal(spd_fix);
          end else begin
            pos_fix = u64_t'(goal) << FRAC;
          end
        end
      endcase
      in_motion = (pos_fix != (u64_t'(goal) << FRAC));
    end
    ipart = pos_fix >> FRAC;
    r.servo_position = (ipart > u64_t'(SERVO_MAX)) ? SERVO_MAX : ipart[7:0];
    r.moving = in_motion;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    servo_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("unexpected transfer", int'(servo_position), -1);
      end else begin
        want = pending_positions.pop_front();
        if (servo_position !== want.servo_position)
          report_mismatch("servo_position", int'(servo_position),
                          int'(want.servo_position));
        if (moving !== want.moving)
          report_mismatch("moving", int'(moving), int'(want.moving));
      end
    end
  end

  // result side ready, with random stalls and requested long holds
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (out_hold_cycles) @(posedge clk);
        out_hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_cmd(input bit m, input logic [1:0] sel);
    int gap;
    in_valid      <= 1'b1;
    mode          <= m;
    target_select <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    pending_positions.push_back(next_servo_output(m, sel));
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] c, m, o, a, t, d);
    put_reg(CFG_CLOSE, c);
    put_reg(CFG_MID, m);
    put_reg(CFG_OPEN, o);
    put_reg(CFG_ACCEL, a);
    put_reg(CFG_TOP, t);
    put_reg(CFG_DPU, d);
    cfg_we    <= 1'b0;
    close_deg = c[7:0];
    mid_deg   = m[7:0];
    open_deg  = o[7:0];
    accel_cfg = a;
    top_cfg   = t[9:0];
    dpu_cfg   = d;
  endtask

  function automatic logic [15:0] random_angle();
    logic [15:0] v;
    v[15:8] = 8'($urandom);
    v[7:0]  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(181, 255))
                                           : 8'($urandom_range(0, 180));
    return v;
  endfunction

  task automatic program_random();
    logic [15:0] a, t, d;
    case ($urandom_range(0, 5))
      0:       a = 16'hFFFF;
      1:       a = 16'($urandom_range(0, 1));
      default: a = 16'($urandom_range(500, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       t = 16'd1023;
      1:       t = 16'd1;
      2:       t = 16'($urandom_range(0, 65535));  // junk above bit 9
      default: t = 16'($urandom_range(100, 1023));
    endcase
    case ($urandom_range(0, 6))
      0:       d = 16'd0;
      1:       d = 16'hFFFF;
      2:       d = 16'd256;
      default: d = 16'($urandom_range(1, 96));
    endcase
    program_regs(random_angle(), random_angle(), random_angle(), a, t, d);
  endtask

  // start + tick bursts, with some early restarts and stray commands
  task automatic run_moves(input int count);
    int first, cap, n;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(0, 99) < 8) begin
        send_cmd(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end else begin
        send_cmd(1'b1, 2'($urandom_range(0, 3)));
        cap = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 8) : $urandom_range(30, 160);
        n = 0;
        while (in_motion && n < cap && items_sent - first < count) begin
          send_cmd(1'b0, 2'($urandom_range(0, 3)));
          n++;
        end
        repeat ($urandom_range(0, 2)) send_cmd(1'b0, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_idle_commands();
    send_cmd(1'b0, SEL_OPEN);     // tick while idle
    send_cmd(1'b1, SEL_CENTRE);   // start at the goal
    send_cmd(1'b1, SEL_CLOSE);
    wait_drained();
  endtask

  task automatic test_extreme_settings();
    program_regs(16'd0, 16'd180, 16'd255, 16'hFFFF, 16'd1023, 16'd1);
    send_cmd(1'b1, SEL_CLOSE);    // overshoot clamps at zero
    repeat (6) send_cmd(1'b0, SEL_CLOSE);
    send_cmd(1'b1, SEL_OPEN);     // goal above the servo range
    repeat (6) send_cmd(1'b0, SEL_CENTRE);
    send_cmd(1'b1, SEL_MID);
    repeat (3) send_cmd(1'b0, SEL_MID);
    wait_drained();
  endtask

  task automatic test_zero_settings();
    program_regs(16'd0, 16'd180, 16'd255, 16'd0, 16'd1023, 16'd0);
    send_cmd(1'b1, SEL_CENTRE);
    repeat (3) send_cmd(1'b0, SEL_OPEN);
    wait_drained();
  endtask

  task automatic test_output_hold();
    program_regs(16'd10, 16'd170, 16'd60, 16'd40000, 16'd800, 16'd8);
    idle_on = 1'b0;
    out_hold_cycles = 300;
    send_cmd(1'b1, SEL_CLOSE);
    repeat (14) send_cmd(1'b0, SEL_CLOSE);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    send_cmd(1'b1, SEL_MID);
    repeat (10) send_cmd(1'b0, SEL_MID);
    wait_drained();
    repeat (10) send_cmd(1'b0, SEL_MID);
    wait_drained();
  endtask

  task automatic test_random_profiles();
    for (int p = 0; p < 10; p++) begin
      if (p == 0)
        program_regs(16'd0, 16'd180, 16'd255, 16'hFFFF, 16'd1023, 16'd1);
      else if (p == 1)
        program_regs(16'd180, 16'd0, 16'd90, 16'd1, 16'd1, 16'hFFFF);
      else
        program_random();
      idle_on = (p % 4 != 3);
      run_moves(125);
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = 1'b0;
    target_select = '0;
    close_deg     = CENTRE_ANGLE;
    mid_deg       = CENTRE_ANGLE;
    open_deg      = CENTRE_ANGLE;
    accel_cfg     = RST_ACCEL;
    top_cfg       = RST_TOP;
    dpu_cfg       = RST_DPU;
    pos_fix       = u64_t'(CENTRE_ANGLE) << FRAC;
    spd_fix       = 0;
    stage         = STG_ACCEL;
    goal          = CENTRE_ANGLE;
    in_motion     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_commands();
    test_extreme_settings();
    test_zero_settings();
    test_output_hold();
    test_pause_until_drained();
    test_random_profiles();

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
